// ===== hdl/rgba_blend_three_mode_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef RGBA_BLEND_THREE_MODE_UNIT_ASSERT_SVH
`define RGBA_BLEND_THREE_MODE_UNIT_ASSERT_SVH

// condition implies a consequence in the same cycle
`define AST_IMPLY(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// condition implies a delayed consequence
`define AST_AFTER2(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##2 (conseq)) \
    else $error(msg);

`endif

// ===== hdl/rbm_pkg.sv =====
`default_nettype none

package rbm_pkg;

  localparam logic [7:0] MAXV = 8'd255;

  // blend mode register codes
  typedef enum logic [1:0] {
    MODE_OVER = 2'd0,
    MODE_MULT = 2'd1,
    MODE_ADD  = 2'd2,
    MODE_KEEP = 2'd3
  } mode_t;

  // which candidate the output stage takes
  typedef enum logic [2:0] {
    PICK_DST  = 3'd0,
    PICK_SRC  = 3'd1,
    PICK_OVER = 3'd2,
    PICK_MULT = 3'd3,
    PICK_ADD  = 3'd4
  } pick_t;

  // control that travels with a word into the output stage
  typedef struct packed {
    logic  valid;
    pick_t pick;
  } ctl_t;

  // per-channel candidates from one lane
  typedef struct packed {
    logic [7:0] dst;
    logic [7:0] src;
    logic [7:0] over;
    logic [7:0] mult;
    logic [7:0] add;
  } lane_res_t;

  // floor(x / 255) for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rbm_lane.sv =====
`default_nettype none

module rbm_lane import rbm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      load,
  input  wire logic [7:0] d,
  input  wire logic [7:0] s,
  input  wire logic [7:0] a1,
  input  wire logic [7:0] a2,
  output lane_res_t      res
);

  logic [15:0] over_sum;
  logic [16:0] add_sum;
  logic [15:0] t1_prod;
  logic [15:0] t2_prod;
  logic [15:0] mult_prod;

  logic [7:0] d_q;
  logic [7:0] s_q;
  logic [7:0] over_q;
  logic [8:0] add_q;
  logic [7:0] t1;
  logic [7:0] t2;

  // first stage products
  always_comb begin
    over_sum = {8'd0, d} * {8'd0, MAXV - a2} + {8'd0, s} * {8'd0, a2};
    add_sum  = {9'd0, d} * {9'd0, a1} + {9'd0, s} * {9'd0, a2};
    t1_prod  = {8'd0, a1} * {8'd0, MAXV - d};
    t2_prod  = {8'd0, a2} * {8'd0, MAXV - s};
  end

  // first stage register
  always_ff @(posedge clk) begin
    if (load) begin
      d_q    <= d;
      s_q    <= s;
      over_q <= over_sum[15:8];
      add_q  <= add_sum[16:8];
      t1     <= MAXV - t1_prod[15:8];
      t2     <= MAXV - t2_prod[15:8];
    end
  end

  // second stage: multiply product and saturation
  assign mult_prod = {8'd0, t1} * {8'd0, t2};

  always_comb begin
    res.dst  = d_q;
    res.src  = s_q;
    res.over = over_q;
    res.mult = mult_prod[15:8];
    res.add  = add_q[8] ? MAXV : add_q[7:0];
  end

endmodule

`default_nettype wire

// ===== hdl/rbm_merge.sv =====
`default_nettype none

module rbm_merge import rbm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ctl_t       ctl_in,
  input  wire logic [7:0] a1,
  input  wire logic [7:0] a2,
  input  wire lane_res_t  lane_red,
  input  wire lane_res_t  lane_green,
  input  wire lane_res_t  lane_blue,
  output logic            done,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_alpha
);

  ctl_t        ctl;
  logic [7:0]  a1_q;
  logic [7:0]  a2_q;
  logic [15:0] alpha_prod;
  logic [7:0]  over_alpha;
  logic [8:0]  add_alpha_sum;
  logic [7:0]  add_alpha;
  logic [7:0]  alpha_next;

  // first stage control and alpha product
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= ctl_in.valid;
    end
    ctl.pick <= ctl_in.pick;
    if (ctl_in.valid) begin
      a1_q       <= a1;
      a2_q       <= a2;
      alpha_prod <= {8'd0, a1} * {8'd0, MAXV - a2};
    end
  end

  // alpha candidates
  always_comb begin
    over_alpha    = a2_q + div255(alpha_prod);
    add_alpha_sum = {1'b0, a1_q} + {1'b0, a2_q};
    add_alpha     = add_alpha_sum[8] ? MAXV : add_alpha_sum[7:0];
  end

  always_comb begin
    case (ctl.pick)
      PICK_SRC:  alpha_next = a2_q;
      PICK_OVER: alpha_next = over_alpha;
      PICK_MULT: alpha_next = MAXV;
      PICK_ADD:  alpha_next = add_alpha;
      default:   alpha_next = a1_q;
    endcase
  end

  function automatic logic [7:0] pick_ch(input pick_t p, input lane_res_t r);
    logic [7:0] v;
    case (p)
      PICK_SRC:  v = r.src;
      PICK_OVER: v = r.over;
      PICK_MULT: v = r.mult;
      PICK_ADD:  v = r.add;
      default:   v = r.dst;
    endcase
    return v;
  endfunction

  // output register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
    if (ctl.valid) begin
      out_red   <= pick_ch(ctl.pick, lane_red);
      out_green <= pick_ch(ctl.pick, lane_green);
      out_blue  <= pick_ch(ctl.pick, lane_blue);
      out_alpha <= alpha_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rgba_blend_three_mode_unit.sv =====
`default_nettype none

// rgba blend unit: composites one 8-bit rgba source pixel over a destination pixel
// input: a word is taken at each rising edge with start high and busy low; busy
//   is always low, so a new pixel may be started every cycle
// output: done is high for exactly one cycle with out_red/green/blue/alpha,
//   via the first stage and output registers; there is no backpressure
// throughput: one pixel per cycle, set by the two-stage channel lanes (products
//   in the first stage, multiply product and selection in the second)
// config: blend_mode is written when blend_mode_we is high; the mode is sampled
//   with each pixel, so words already in flight keep their mode
//   0 over, 1 multiplicative, 2 additive saturating, 3 keep destination
// special cases: a transparent source passes the destination; an empty
//   destination or opaque source copies the source
// reset: rst clears the pipeline valid bits and sets the mode to over;
//   no word is in flight afterwards
module rgba_blend_three_mode_unit import rbm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       blend_mode_we,
  input  wire logic [1:0] blend_mode,
  input  wire logic [7:0] dst_red,
  input  wire logic [7:0] dst_green,
  input  wire logic [7:0] dst_blue,
  input  wire logic [7:0] dst_alpha,
  input  wire logic [7:0] src_red,
  input  wire logic [7:0] src_green,
  input  wire logic [7:0] src_blue,
  input  wire logic [7:0] src_alpha,
  output logic            done,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_alpha
);

  mode_t     mode;
  ctl_t      ctl_in;
  logic      load;
  lane_res_t lane_red;
  lane_res_t lane_green;
  lane_res_t lane_blue;

  assign busy = 1'b0;
  assign load = start && !busy;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_OVER;
    end else if (blend_mode_we) begin
      mode <= mode_t'(blend_mode);
    end
  end

  // special cases and mode decide the candidate
  always_comb begin
    ctl_in.valid = load;
    if (src_alpha == 8'd0) begin
      ctl_in.pick = PICK_DST;
    end else if (dst_alpha == 8'd0 || src_alpha == MAXV) begin
      ctl_in.pick = PICK_SRC;
    end else begin
      case (mode)
        MODE_OVER: ctl_in.pick = PICK_OVER;
        MODE_MULT: ctl_in.pick = PICK_MULT;
        MODE_ADD:  ctl_in.pick = PICK_ADD;
        default:   ctl_in.pick = PICK_DST;
      endcase
    end
  end

  // one lane per color channel
  rbm_lane u_lane_red (
    .clk  (clk),
    .load (load),
    .d    (dst_red),
    .s    (src_red),
    .a1   (dst_alpha),
    .a2   (src_alpha),
    .res  (lane_red)
  );

  rbm_lane u_lane_green (
    .clk  (clk),
    .load (load),
    .d    (dst_green),
    .s    (src_green),
    .a1   (dst_alpha),
    .a2   (src_alpha),
    .res  (lane_green)
  );

  rbm_lane u_lane_blue (
    .clk  (clk),
    .load (load),
    .d    (dst_blue),
    .s    (src_blue),
    .a1   (dst_alpha),
    .a2   (src_alpha),
    .res  (lane_blue)
  );

  // alpha path and output selection
  rbm_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .ctl_in     (ctl_in),
    .a1         (dst_alpha),
    .a2         (src_alpha),
    .lane_red   (lane_red),
    .lane_green (lane_green),
    .lane_blue  (lane_blue),
    .done       (done),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha)
  );

endmodule

`default_nettype wire

// ===== hdl/rbm_check.sv =====
`default_nettype none

`include "rgba_blend_three_mode_unit_assert.svh"

module rbm_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [7:0] dst_red,
  input wire logic [7:0] dst_green,
  input wire logic [7:0] dst_blue,
  input wire logic [7:0] dst_alpha,
  input wire logic [7:0] src_red,
  input wire logic [7:0] src_green,
  input wire logic [7:0] src_blue,
  input wire logic [7:0] src_alpha,
  input wire logic       done,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue,
  input wire logic [7:0] out_alpha
);

  logic acc;
  assign acc = start && !busy;

  // every accepted word gives a strobe once it reaches the output register
  `AST_AFTER2(a_done_follows, clk, rst, acc, done, "no done two cycles after accept")

  // no strobe without an earlier accepted word
  `AST_IMPLY(a_done_sourced, clk, rst, done, $past(acc, 2), "done without accepted word")

  // transparent source passes the destination
  `AST_AFTER2(a_pass_dst, clk, rst, acc && src_alpha == 8'd0, out_red == $past(dst_red, 2) && out_green == $past(dst_green, 2) && out_blue == $past(dst_blue, 2) && out_alpha == $past(dst_alpha, 2), "transparent source did not pass destination")

  // opaque source is copied
  `AST_AFTER2(a_copy_src, clk, rst, acc && src_alpha == 8'd255, out_red == $past(src_red, 2) && out_green == $past(src_green, 2) && out_blue == $past(src_blue, 2) && out_alpha == 8'd255, "opaque source not copied")

endmodule

bind rgba_blend_three_mode_unit rbm_check u_check (.*);

`default_nettype wire
